FILE: rtl/core/rmt_pkg.sv
// Shared types and constants for the range minimum tree block.
// Depends on nothing; the walker, the top level and the testbench import it.
`default_nettype none
package rmt_pkg;

  localparam int VAL_W  = 31;
  localparam int POS_W  = 10;
  localparam int SIZE_W = 11;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [SIZE_W-1:0]       size_t;

  localparam val_t  EMPTY_MIN  = 31'sd1000000000;
  localparam size_t SIZE_RESET = 11'd1024;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // One decoded item as handed to the tree walker.
  typedef struct packed {
    op_t  op;
    logic empty;
    val_t value;
    pos_t pos;
    pos_t lo;
    pos_t hi;
  } cmd_t;

  typedef struct packed {
    val_t minimum;
    logic empty;
  } res_t;

  function automatic val_t min_val(input val_t a, input val_t b);
    return (a < b) ? a : b;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rmt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used for the tree node store.
`default_nettype none
module rmt_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/rmt_walker.sv
// Tree walker: clears the node store after reset, then walks the tree for
// point writes (leaf to root) and range queries. Uses rmt_pkg and rmt_ram.
`default_nettype none
module rmt_walker #(
  parameter int LEAVES = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire rmt_pkg::cmd_t cmd,
  output logic               res_valid,
  input  wire logic          res_ready,
  output rmt_pkg::res_t      res
);
  import rmt_pkg::*;

  localparam int NODES = 2 * LEAVES;
  localparam int AW    = $clog2(NODES);
  localparam int NW    = $clog2(NODES + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WUPD,
    S_QL,
    S_QR,
    S_RES
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] k_r, k_nxt;
  val_t          cur_r, cur_nxt;
  logic [NW-1:0] l_r, l_nxt;
  logic [NW-1:0] r_r, r_nxt;
  val_t          best_r, best_nxt;
  logic          found_r, found_nxt;
  logic          pend_r, pend_nxt;
  res_t          res_r, res_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  val_t          mem_wdata;
  logic [AW-1:0] mem_raddr;
  val_t          mem_rdata;

  logic [AW-1:0] leaf;
  logic [AW-1:0] parent;
  logic [NW-1:0] r_dec;
  logic [NW-1:0] r_aft;
  val_t          walk_min;

  rmt_ram #(
    .WIDTH(VAL_W),
    .DEPTH(NODES)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign leaf      = AW'(LEAVES) + AW'(cmd.pos);
  assign parent    = k_r >> 1;
  assign r_dec     = r_r - NW'(1);
  assign walk_min  = min_val(cur_r, mem_rdata);
  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RES);
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    best_nxt  = best_r;
    found_nxt = found_r;
    pend_nxt  = 1'b0;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = k_r;
    mem_wdata = cur_r;
    mem_raddr = k_r ^ AW'(1);
    r_aft     = r_r;

    // A node read issued last cycle is folded into the running minimum now.
    if (pend_r) begin
      best_nxt  = found_r ? min_val(best_r, mem_rdata) : mem_rdata;
      found_nxt = 1'b1;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = leaf;
            mem_wdata = cmd.value;
            mem_raddr = leaf ^ AW'(1);
            k_nxt     = leaf;
            cur_nxt   = cmd.value;
            state_nxt = S_WUPD;
          end else if (cmd.empty) begin
            res_nxt   = '{minimum: EMPTY_MIN, empty: 1'b1};
            state_nxt = S_RES;
          end else begin
            l_nxt     = NW'(LEAVES) + NW'(cmd.lo);
            r_nxt     = NW'(LEAVES) + NW'(cmd.hi) + NW'(1);
            found_nxt = 1'b0;
            state_nxt = S_QL;
          end
        end
      end
      S_WUPD: begin
        // The sibling arrives now; write the parent and fetch its sibling.
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = walk_min;
        cur_nxt   = walk_min;
        mem_raddr = parent ^ AW'(1);
        k_nxt     = parent;
        if (parent == AW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_QL: begin
        if (l_r < r_r) begin
          if (l_r[0]) begin
            mem_raddr = l_r[AW-1:0];
            pend_nxt  = 1'b1;
            l_nxt     = l_r + NW'(1);
          end
          state_nxt = S_QR;
        end else begin
          res_nxt   = '{minimum: best_nxt, empty: 1'b0};
          state_nxt = S_RES;
        end
      end
      S_QR: begin
        if (r_r[0]) begin
          r_aft     = r_dec;
          mem_raddr = r_dec[AW-1:0];
          pend_nxt  = 1'b1;
        end
        l_nxt     = l_r >> 1;
        r_nxt     = r_aft >> 1;
        state_nxt = S_QL;
      end
      S_RES: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
    end
    k_r    <= k_nxt;
    cur_r  <= cur_nxt;
    l_r    <= l_nxt;
    r_r    <= r_nxt;
    best_r <= best_nxt;
    res_r  <= res_nxt;
  end

`ifndef NO_ASSERTIONS
  a_ql_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QR) |-> (l_r <= r_r))
    else $error("query walk left bound passed right bound");

  a_walk_above_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WUPD) |-> (k_r >= AW'(2)))
    else $error("write walk went past the root");

  a_found_before_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && !res_r.empty) |-> found_r)
    else $error("nonempty query result without any node read");

  a_pend_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_QL || state_r == S_QR))
    else $error("pending node read outside a query walk");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/range_minimum_tree_top.sv
// Top level of the range minimum tree: config register, item decode and
// output register. Uses rmt_pkg and rmt_walker.
//
//   channel | ports                              | direction
//   in      | in_valid/in_ready + item fields    | into the block
//   out     | out_valid/out_ready + result fields| out of the block
//   cfg     | cfg_valid/cfg_ready + size_in_use  | into the block
//
// After reset the node store is cleared one entry a cycle, all 2*LEAVES entries,
// during which no item is taken; cfg writes are. A point write walks from the
// leaf to the root, one tree level per cycle. A query visits each level in
// S_QL and then S_QR, as the store has a single read port. An empty query goes
// straight to the result state. A waiting result in the output register does
// not stop the next item; it holds the walker only when a second result is ready.
`default_nettype none
module range_minimum_tree_top #(
  parameter int LEAVES = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_operation,
  input  wire logic [9:0]             in_position,
  input  wire logic signed [30:0]     in_new_value,
  input  wire logic [9:0]             in_range_low,
  input  wire logic [9:0]             in_range_high,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [30:0]          out_minimum,
  output logic                        out_range_empty,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [10:0]            cfg_size_in_use
);
  import rmt_pkg::*;

  localparam int LEAVES_CAP = (LEAVES > 2047) ? 2047 : LEAVES;

  size_t size_r;
  size_t size_eff;
  size_t size_lim;
  logic  q_empty;
  pos_t  hi_clip;

  cmd_t  cmd;
  logic  cmd_valid;
  logic  cmd_ready;
  logic  res_valid;
  logic  res_ready;
  res_t  res;

  logic  out_valid_r;
  val_t  out_minimum_r;
  logic  out_empty_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_size_in_use;
    end
  end

  // A size above the tree width acts as the tree width.
  always_comb begin
    size_eff = (int'(size_r) > LEAVES) ? SIZE_W'(LEAVES_CAP) : size_r;
    size_lim = size_eff - SIZE_W'(1);
    q_empty  = (size_eff == '0) || (in_range_low > in_range_high) ||
               ({1'b0, in_range_low} >= size_eff);
    hi_clip  = ({1'b0, in_range_high} > size_lim) ? size_lim[POS_W-1:0] : in_range_high;
  end

  always_comb begin
    cmd.op    = op_t'(in_operation);
    cmd.empty = q_empty;
    cmd.value = in_new_value;
    cmd.pos   = in_position;
    cmd.lo    = in_range_low;
    cmd.hi    = hi_clip;
  end

  // A write beyond the tree is taken and dropped.
  assign cmd_valid = in_valid &&
                     ((op_t'(in_operation) == OP_QUERY) || (int'(in_position) < LEAVES));
  assign in_ready  = cmd_ready;

  rmt_walker #(
    .LEAVES(LEAVES)
  ) u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_minimum_r <= res.minimum;
      out_empty_r   <= res.empty;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_minimum     = out_minimum_r;
  assign out_range_empty = out_empty_r;

endmodule
`default_nettype wire

FILE: verif/tb_range_minimum_tree_top.sv
// Self-checking testbench for range_minimum_tree_top: point writes and range
// minimum queries checked against a behavioral tree kept here. Uses rmt_pkg.
`timescale 1ns / 1ps

module tb_range_minimum_tree_top;
  import rmt_pkg::*;

  localparam int LEAVES         = 1024;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 94;
  localparam int REPORT_LIMIT   = 10;

  localparam val_t VAL_MOST  = val_t'(31'h3FFF_FFFF);
  localparam val_t VAL_LEAST = val_t'(31'h4000_0000);

  typedef struct {
    op_t  op;
    pos_t pos;
    val_t value;
    pos_t lo;
    pos_t hi;
  } tree_op_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic        in_operation    = 1'b0;
  pos_t        in_position     = '0;
  val_t        in_new_value    = '0;
  pos_t        in_range_low    = '0;
  pos_t        in_range_high   = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  val_t        out_minimum;
  logic        out_range_empty;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  size_t       cfg_size_in_use = '0;

  // Behavioral copy of the tree and of the size register.
  val_t        node_min [2*LEAVES];
  size_t       size_reg;

  tree_op_t    pending_ops[$];
  res_t        expected_minima[$];

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          errors         = 0;
  int          writes_taken   = 0;
  int          queries_taken  = 0;
  int          empty_results  = 0;
  int          size_writes    = 0;
  int          idle_cycles    = 0;

  range_minimum_tree_top #(.LEAVES(LEAVES)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_new_value    (in_new_value),
    .in_range_low    (in_range_low),
    .in_range_high   (in_range_high),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_minimum     (out_minimum),
    .out_range_empty (out_range_empty),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_size_in_use (cfg_size_in_use)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void store_element(input pos_t pos, input val_t v);
    int k;
    k = int'(pos) + LEAVES;
    node_min[k] = v;
    while (k > 1) begin
      k = k >> 1;
      node_min[k] = (node_min[2*k] < node_min[2*k+1]) ? node_min[2*k] : node_min[2*k+1];
    end
  endfunction

  function automatic res_t predict_range_min(input pos_t lo_in, input pos_t hi_in);
    res_t r;
    int   eff, lo, hi, l, rr;
    bit   found;
    val_t best;
    eff = (size_reg > LEAVES) ? LEAVES : int'(size_reg);
    lo  = int'(lo_in);
    hi  = int'(hi_in);
    if (eff == 0 || lo > hi || lo >= eff) begin
      r.minimum = EMPTY_MIN;
      r.empty   = 1'b1;
      return r;
    end
    if (hi > eff - 1) hi = eff - 1;
    l     = lo + LEAVES;
    rr    = hi + LEAVES + 1;
    found = 1'b0;
    best  = '0;
    // Bottom-up walk: an odd left bound is taken whole; an odd exclusive right bound takes the node left of it.
    while (l < rr) begin
      if ((l & 1) != 0) begin
        best  = (found && best < node_min[l]) ? best : node_min[l];
        found = 1'b1;
        l++;
      end
      if ((rr & 1) != 0) begin
        rr--;
        best  = (found && best < node_min[rr]) ? best : node_min[rr];
        found = 1'b1;
      end
      l  = l >> 1;
      rr = rr >> 1;
    end
    r.minimum = best;
    r.empty   = 1'b0;
    return r;
  endfunction

  function automatic val_t random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 78) return val_t'(int'($urandom_range(2000000000)) - 1000000000);
    if (pick < 90) return val_t'($urandom);
    if (pick < 95) return (pick % 2 == 0) ? val_t'(1000000000) : val_t'(-1000000000);
    return val_t'(int'($urandom_range(20)) - 10);
  endfunction

  function automatic int clamp_pos(input int p);
    return (p > LEAVES - 1) ? LEAVES - 1 : p;
  endfunction

  // Fields that the operation does not use still carry random bits.
  function automatic void push_write(input int pos, input val_t v);
    tree_op_t t;
    t.op    = OP_WRITE;
    t.pos   = pos_t'(pos);
    t.value = v;
    t.lo    = pos_t'($urandom);
    t.hi    = pos_t'($urandom);
    pending_ops.push_back(t);
  endfunction

  function automatic void push_query(input int lo, input int hi);
    tree_op_t t;
    t.op    = OP_QUERY;
    t.pos   = pos_t'($urandom);
    t.value = val_t'($urandom);
    t.lo    = pos_t'(lo);
    t.hi    = pos_t'(hi);
    pending_ops.push_back(t);
  endfunction

  function automatic void push_random(input int span);
    int a, b, pick;
    pick = $urandom_range(99);
    a    = $urandom_range(span - 1);
    if (pick < 30) begin
      b = a + $urandom_range(7);
    end else if (pick < 60) begin
      b = a + $urandom_range(span - a + 3);
    end else if (pick < 75) begin
      b = a;
      a = a + $urandom_range(8, 1);
    end else begin
      a = $urandom_range(LEAVES - 1);
      b = $urandom_range(LEAVES - 1);
    end
    if ($urandom_range(99) < 45) begin
      push_write(($urandom_range(9) < 8) ? $urandom_range(span - 1) : $urandom_range(LEAVES - 1),
                 random_value());
    end else begin
      push_query(clamp_pos(a), clamp_pos(b));
    end
  endfunction

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid || expected_minima.size() != 0)
      @(negedge clk);
  endtask

  // The block must be idle: any point write still walking the tree has to finish.
  task automatic configure_size(input size_t v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_size_in_use <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = v;
    size_writes++;
    @(negedge clk);
  endtask

  // Item driver: predicts each accepted item and offers the next pending one.
  always @(posedge clk) begin : item_driver
    tree_op_t nxt_op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (op_t'(in_operation) == OP_WRITE) begin
          store_element(in_position, in_new_value);
          writes_taken++;
        end else begin
          expected_minima.push_back(predict_range_min(in_range_low, in_range_high));
          queries_taken++;
        end
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_op = pending_ops.pop_front();
          in_operation  <= nxt_op.op;
          in_position   <= nxt_op.pos;
          in_new_value  <= nxt_op.value;
          in_range_low  <= nxt_op.lo;
          in_range_high <= nxt_op.hi;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    res_t exp_res;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_minima.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: unexpected result: min %0d empty %0b", out_minimum, out_range_empty);
      end else begin
        exp_res = expected_minima.pop_front();
        if (exp_res.empty) empty_results++;
        if (out_minimum !== exp_res.minimum || out_range_empty !== exp_res.empty) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("ERROR: query result: expected min %0d empty %0b, got min %0d empty %0b",
                     exp_res.minimum, exp_res.empty, out_minimum, out_range_empty);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("range_minimum_tree_top: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int    send_modes [4];
    int    recv_modes [4];
    size_t size_plan [PHASES];
    int    span;
    send_modes = '{0, 80, 0, 12};
    recv_modes = '{0, 0, 80, 12};
    size_plan  = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd2,
                   size_t'($urandom_range(1023, 3)), 11'd1000, 11'd512};
    foreach (node_min[i]) node_min[i] = '0;
    size_reg = SIZE_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The store is all zeros after reset.
    configure_size(SIZE_RESET);
    push_query(0, 1023);
    push_write(0, val_t'(-1000000000));
    push_write(1023, val_t'(1000000000));
    push_write(512, VAL_MOST);
    push_write(5, VAL_LEAST);
    push_query(0, 1023);
    push_query(0, 0);
    push_query(1023, 1023);
    push_query(512, 512);
    push_query(10, 3);
    push_query(6, 1022);
    // The range end is clipped to the size; a start at or past it is empty.
    configure_size(11'd4);
    push_query(0, 1023);
    push_query(4, 10);
    push_query(3, 3);
    push_write(900, val_t'(-5));
    push_query(0, 1023);
    configure_size(11'd0);
    push_query(0, 0);
    push_write(1, val_t'(7));
    // An oversized register acts as the full array and reveals the earlier write.
    configure_size(11'd2047);
    push_query(900, 900);
    push_query(0, 1023);
    push_query(1, 1);

    for (int p = 0; p < PHASES; p++) begin
      configure_size(size_plan[p]);
      span = (size_plan[p] == 0 || size_plan[p] > LEAVES) ? LEAVES : int'(size_plan[p]);
      send_idle_pct  = send_modes[p % 4];
      recv_stall_pct = recv_modes[p % 4];
      if (p % 2 == 1) begin
        // The sender holds off halfway until every outstanding query has answered.
        repeat (PHASE_ITEMS / 2) push_random(span);
        wait_drained();
        repeat (PHASE_ITEMS - PHASE_ITEMS / 2) push_random(span);
      end else begin
        repeat (PHASE_ITEMS) push_random(span);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_minima.size() != 0) begin
      errors++;
      $display("ERROR: %0d query results never arrived", expected_minima.size());
    end
    $display("Ran %0d point writes and %0d range queries (%0d empty) across %0d size settings,",
             writes_taken, queries_taken, empty_results, size_writes);
    $display("with sender gaps and receiver stalls in four mixes; %0d errors.", errors);
    if (errors == 0) begin
      $display("range_minimum_tree_top: match");
    end else begin
      $display("range_minimum_tree_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: range_minimum_tree_top.f
rtl/core/rmt_pkg.sv
rtl/core/rmt_ram.sv
rtl/core/rmt_walker.sv
rtl/core/range_minimum_tree_top.sv
verif/tb_range_minimum_tree_top.sv
